@@ hdl/dr_pkg.sv @@
`timescale 1ns / 1ps

package dr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W     = 34;   // Q2.30 plus headroom
  localparam int POS_W        = 48;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [16:0]      trig_t;   // Q1.15, clamped to +/-32767
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [34:0]      mul_a_t;
  typedef logic signed [17:0]      mul_b_t;
  typedef logic signed [52:0]      prod_t;

  typedef struct packed {
    logic  done;
    trig_t cos_q;
    trig_t sin_q;
  } dr_trig_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [29:0] a;
    case (idx)
      4'd0:    a = 30'd536870912;
      4'd1:    a = 30'd316933406;
      4'd2:    a = 30'd167458907;
      4'd3:    a = 30'd85004756;
      4'd4:    a = 30'd42667331;
      4'd5:    a = 30'd21354465;
      4'd6:    a = 30'd10679838;
      4'd7:    a = 30'd5340245;
      4'd8:    a = 30'd2670163;
      4'd9:    a = 30'd1335087;
      4'd10:   a = 30'd667544;
      4'd11:   a = 30'd333772;
      4'd12:   a = 30'd166886;
      4'd13:   a = 30'd83443;
      4'd14:   a = 30'd41722;
      4'd15:   a = 30'd20861;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/dr_ifs.sv @@
`timescale 1ns / 1ps

interface dr_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        timestamp;
  logic signed [15:0] vel_forward;
  logic signed [15:0] vel_lateral;
  logic signed [15:0] turn_rate;

  modport source (output valid, timestamp, vel_forward, vel_lateral, turn_rate,
                  input ready);
  modport sink   (input valid, timestamp, vel_forward, vel_lateral, turn_rate,
                  output ready);
endinterface

interface dr_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic [31:0]        heading;
  logic               elapsed_clamped;

  modport source (output valid, pos_x, pos_y, heading, elapsed_clamped,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading, elapsed_clamped,
                  output ready);
endinterface

@@ hdl/dr_mul.sv @@
`timescale 1ns / 1ps

module dr_mul (
  input  logic           clk,
  input  dr_pkg::mul_a_t a,
  input  dr_pkg::mul_b_t b,
  output dr_pkg::prod_t  p_r
);
  import dr_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

@@ hdl/dr_cordic.sv @@
`timescale 1ns / 1ps

module dr_cordic #(
  parameter int ANGLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output dr_pkg::dr_trig_t      trig
);
  import dr_pkg::*;

  localparam logic signed [CORDIC_W-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [CORDIC_W-1:0] HALF    = 34'sd2147483648;
  localparam logic [STEP_W-1:0]          LAST_I  = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic signed [CORDIC_W-1:0] z_in, z_fold, xs, ys, at;
  logic [STEP_W-1:0]          i_r;
  logic                       busy_r, fin_r, done_r, neg_r, neg_in;
  trig_t                      cos_r, sin_r;

  function automatic trig_t to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    trig_t                      q;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767)       q = 17'sd32767;
    else if (r < -34'sd32767) q = -17'sd32767;
    else                      q = r[16:0];
    return q;
  endfunction

  // top bits of the heading as a signed angle, folded into +/- quarter turn
  assign z_in = {{2{angle[ANGLE_BITS-1]}}, angle, {(32-ANGLE_BITS){1'b0}}};

  always_comb begin
    neg_in = 1'b0;
    z_fold = z_in;
    if (z_in > QUARTER) begin
      z_fold = z_in - HALF;
      neg_in = 1'b1;
    end else if (z_in < -QUARTER) begin
      z_fold = z_in + HALF;
      neg_in = 1'b1;
    end
  end

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = {4'b0000, atan_turn(i_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == LAST_I) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= z_fold;
      neg_r <= neg_in;
    end else if (busy_r) begin
      if (!z_r[CORDIC_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end else if (fin_r) begin
      cos_r <= to_q15(neg_r ? -x_r : x_r);
      sin_r <= to_q15(neg_r ? -y_r : y_r);
    end
  end

  assign trig.done  = done_r;
  assign trig.cos_q = cos_r;
  assign trig.sin_q = sin_r;

endmodule

@@ hdl/planar_dead_reckoning_top.sv @@
// channel  dir  handshake          payload
// in_if    in   valid/ready        timestamp, vel_forward, vel_lateral, turn_rate
// out_if   out  valid/ready        pos_x, pos_y, heading, elapsed_clamped
// cfg_*    in   cfg_we (no wait)   cfg_wdata = max_elapsed_ticks
//
// Steps per item: 16 CORDIC rotations, rounding, done, ten multiplies and a
// drain on the shared 35x18 multiplier, update, output load, idle.
// in_if.ready is high only in the idle state; one item is in flight at a time.
// A result sits in the output register until taken; the next beat is accepted
// meanwhile but its result is held back until the register is free.
// rst_n is synchronous: position, heading, last timestamp clear, limit = 65536.
`timescale 1ns / 1ps

module planar_dead_reckoning_top #(
  parameter int TRIG_ANGLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  dr_in_if.sink       in_if,
  dr_out_if.source    out_if,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import dr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRIG = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // multiplier operations, issued in this order
  localparam logic [3:0] OP_FC   = 4'd0;  // fwd * cos
  localparam logic [3:0] OP_LS   = 4'd1;  // lat * sin
  localparam logic [3:0] OP_FS   = 4'd2;  // fwd * sin
  localparam logic [3:0] OP_LC   = 4'd3;  // lat * cos
  localparam logic [3:0] OP_AL   = 4'd4;  // A * dt[15:0]
  localparam logic [3:0] OP_AH   = 4'd5;  // A * dt[31:16]
  localparam logic [3:0] OP_BL   = 4'd6;
  localparam logic [3:0] OP_BH   = 4'd7;
  localparam logic [3:0] OP_YL   = 4'd8;  // yaw * dt[15:0]
  localparam logic [3:0] OP_YH   = 4'd9;
  localparam logic [3:0] OP_LAST = 4'd10; // drain the last product

  localparam logic signed [66:0] POS_MAX67 = 67'sd140737488355327;
  localparam logic signed [66:0] POS_MIN67 = -67'sd140737488355328;

  logic [2:0]         state_r, state_nxt;
  logic [31:0]        max_r, last_ts_r, dt_r, dt_raw, heading_r, heading_nxt;
  logic               clamped_r, in_fire, out_load, out_valid_r;
  logic signed [15:0] fwd_r, lat_r, yaw_r;
  logic [3:0]         step_r, prev_op;
  logic signed [33:0] a_r, b_r;
  logic signed [65:0] dx_r, dy_r, p66;
  logic [27:0]        dh_r;
  pos_t               world_x_r, world_y_r, world_x_nxt, world_y_nxt;
  pos_t               pos_x_r, pos_y_r;
  logic [31:0]        heading_out_r;
  logic               clamped_out_r;
  mul_a_t             mul_a;
  mul_b_t             mul_b;
  prod_t              prod_r;
  dr_trig_t           trig;

  function automatic pos_t sat_add(input pos_t w, input logic signed [65:0] d);
    logic signed [65:0] r;
    logic signed [66:0] s;
    pos_t               q;
    r = (d + 66'sd16384) >>> 15;
    s = {{19{w[POS_W-1]}}, w} + {r[65], r};
    if (s > POS_MAX67)      q = POS_MAX67[POS_W-1:0];
    else if (s < POS_MIN67) q = POS_MIN67[POS_W-1:0];
    else                    q = s[POS_W-1:0];
    return q;
  endfunction

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign dt_raw      = in_if.timestamp - last_ts_r;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_if.ready);

  dr_cordic #(.ANGLE_BITS(TRIG_ANGLE_BITS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .angle (heading_r[31 -: TRIG_ANGLE_BITS]),
    .trig  (trig)
  );

  always_comb begin
    case (step_r)
      OP_FC:   begin mul_a = 35'(fwd_r);   mul_b = 18'(trig.cos_q); end
      OP_LS:   begin mul_a = 35'(lat_r);   mul_b = 18'(trig.sin_q); end
      OP_FS:   begin mul_a = 35'(fwd_r);   mul_b = 18'(trig.sin_q); end
      OP_LC:   begin mul_a = 35'(lat_r);   mul_b = 18'(trig.cos_q); end
      OP_AL:   begin mul_a = 35'(a_r);     mul_b = {2'b00, dt_r[15:0]};  end
      OP_AH:   begin mul_a = 35'(a_r);     mul_b = {2'b00, dt_r[31:16]}; end
      OP_BL:   begin mul_a = 35'(b_r);     mul_b = {2'b00, dt_r[15:0]};  end
      OP_BH:   begin mul_a = 35'(b_r);     mul_b = {2'b00, dt_r[31:16]}; end
      OP_YL:   begin mul_a = 35'(yaw_r);   mul_b = {2'b00, dt_r[15:0]};  end
      OP_YH:   begin mul_a = 35'(yaw_r);   mul_b = {2'b00, dt_r[31:16]}; end
      default: begin mul_a = '0;           mul_b = '0; end
    endcase
  end

  dr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  assign prev_op = step_r - 4'd1;
  assign p66     = 66'(prod_r);

  assign world_x_nxt = sat_add(world_x_r, dx_r);
  assign world_y_nxt = sat_add(world_y_r, dy_r);
  assign heading_nxt = heading_r + {dh_r, 4'b0000};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_TRIG;
      S_TRIG:  if (trig.done) state_nxt = S_MUL;
      S_MUL:   if (step_r == OP_LAST) state_nxt = S_UPD;
      S_UPD:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= 32'd65536;
      last_ts_r   <= '0;
      heading_r   <= '0;
      world_x_r   <= '0;
      world_y_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) max_r <= cfg_wdata;
      if (in_fire) last_ts_r <= in_if.timestamp;
      if (state_r == S_MUL) step_r <= step_r + 4'd1;
      else                  step_r <= '0;
      if (state_r == S_UPD) begin
        world_x_r <= world_x_nxt;
        world_y_r <= world_y_nxt;
        heading_r <= heading_nxt;
      end
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_r <= in_if.vel_forward;
      lat_r <= in_if.vel_lateral;
      yaw_r <= in_if.turn_rate;
      if (dt_raw > max_r) begin
        dt_r      <= max_r;
        clamped_r <= 1'b1;
      end else begin
        dt_r      <= dt_raw;
        clamped_r <= 1'b0;
      end
    end
    if (state_r == S_MUL) begin
      case (prev_op)
        OP_FC:   a_r  <= prod_r[33:0];
        OP_LS:   a_r  <= a_r - prod_r[33:0];
        OP_FS:   b_r  <= prod_r[33:0];
        OP_LC:   b_r  <= b_r + prod_r[33:0];
        OP_AL:   dx_r <= p66;
        OP_AH:   dx_r <= dx_r + (p66 <<< 16);
        OP_BL:   dy_r <= p66;
        OP_BH:   dy_r <= dy_r + (p66 <<< 16);
        OP_YL:   dh_r <= prod_r[27:0];
        OP_YH:   dh_r <= dh_r + {prod_r[11:0], 16'h0000};
        default: ;
      endcase
    end
    if (out_load) begin
      pos_x_r       <= world_x_r;
      pos_y_r       <= world_y_r;
      heading_out_r <= heading_r;
      clamped_out_r <= clamped_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.pos_x           = pos_x_r;
  assign out_if.pos_y           = pos_y_r;
  assign out_if.heading         = heading_out_r;
  assign out_if.elapsed_clamped = clamped_out_r;

endmodule
